@@ hdl/isbn10_pkg.sv @@
// Package for the ISBN-10 validator: state record, character codes and helpers.
package isbn10_pkg;

	localparam logic [7:0] CHAR_DASH    = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UPPER_X = 8'h58;
	localparam logic [7:0] CHAR_LOWER_X = 8'h78;

	localparam logic [3:0] LEN_PLAIN     = 4'd10;
	localparam logic [3:0] LEN_DASHED    = 4'd13;
	localparam logic [3:0] LEN_MAX       = 4'd15;
	localparam logic [2:0] DASHES_NEEDED = 3'd3;
	localparam logic [2:0] DASH_MAX      = 3'd7;
	localparam logic [3:0] CHECK_TEN     = 4'd10;
	localparam logic [3:0] MOD_ELEVEN    = 4'd11;

	typedef struct packed {
		logic [3:0] char_count;
		logic [2:0] dash_count;
		logic [3:0] digit_weight;
		logic [3:0] sum_mod_eleven;
		logic       prev_was_dash;
		logic       error_seen;
	} isbn_state_t;

	// Residue modulo 11 of a value below 176, by four compare-and-subtract steps.
	function automatic logic [3:0] mod_eleven(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (r >= 8'd88) r = r - 8'd88;
		if (r >= 8'd44) r = r - 8'd44;
		if (r >= 8'd22) r = r - 8'd22;
		if (r >= 8'd11) r = r - 8'd11;
		return r[3:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

endpackage

@@ hdl/isbn10_step.sv @@
// Per-character state update and final verdict for the ISBN-10 validator.
module isbn10_step (
	input  isbn10_pkg::isbn_state_t state_cur,
	input  logic [7:0]              char_code,
	input  logic                    is_final,
	output isbn10_pkg::isbn_state_t state_nxt,
	output logic                    valid_res
);

	logic       dash;
	logic       digit;
	logic [3:0] digit_val;
	logic [3:0] weight_nxt;
	logic [7:0] product;
	logic [7:0] sum_ext;
	logic [3:0] len;
	logic [3:0] check;
	logic       check_ok;
	logic       len_ok;

	assign dash       = (char_code == isbn10_pkg::CHAR_DASH);
	assign digit      = isbn10_pkg::is_digit(char_code);
	assign digit_val  = 4'(char_code - isbn10_pkg::CHAR_ZERO);
	assign weight_nxt = (state_cur.digit_weight < isbn10_pkg::LEN_MAX) ?
		state_cur.digit_weight + 4'd1 : state_cur.digit_weight;
	assign product    = {4'd0, digit_val} * {4'd0, weight_nxt};
	assign sum_ext    = product + {4'd0, state_cur.sum_mod_eleven};

	assign len = (state_cur.char_count < isbn10_pkg::LEN_MAX) ?
		state_cur.char_count + 4'd1 : isbn10_pkg::LEN_MAX;

	always_comb begin
		check    = 4'd0;
		check_ok = 1'b1;
		if (char_code == isbn10_pkg::CHAR_UPPER_X || char_code == isbn10_pkg::CHAR_LOWER_X) begin
			check = isbn10_pkg::CHECK_TEN;
		end else if (digit) begin
			check = digit_val;
		end else begin
			check_ok = 1'b0;
		end
	end

	always_comb begin
		len_ok = 1'b0;
		if (len == isbn10_pkg::LEN_PLAIN) begin
			len_ok = (state_cur.dash_count == 3'd0);
		end else if (len == isbn10_pkg::LEN_DASHED) begin
			len_ok = (state_cur.dash_count == isbn10_pkg::DASHES_NEEDED);
		end
	end

	assign valid_res = !state_cur.error_seen && len_ok && check_ok &&
		(state_cur.sum_mod_eleven == check);

	always_comb begin
		state_nxt = state_cur;
		if (is_final) begin
			state_nxt = '0;
		end else begin
			if (dash) begin
				if (state_cur.char_count == 4'd0 || state_cur.prev_was_dash)
					state_nxt.error_seen = 1'b1;
				if (state_cur.dash_count < isbn10_pkg::DASH_MAX)
					state_nxt.dash_count = state_cur.dash_count + 3'd1;
				state_nxt.prev_was_dash = 1'b1;
			end else begin
				if (!digit) begin
					state_nxt.error_seen = 1'b1;
				end else begin
					state_nxt.digit_weight   = weight_nxt;
					state_nxt.sum_mod_eleven = isbn10_pkg::mod_eleven(sum_ext);
				end
				state_nxt.prev_was_dash = 1'b0;
			end
			if (state_cur.char_count < isbn10_pkg::LEN_MAX)
				state_nxt.char_count = state_cur.char_count + 4'd1;
		end
	end

endmodule

@@ hdl/isbn10_dashed_validator.sv @@
// Top level of the streaming ISBN-10 validator for dashed or plain strings.
//
// Usage: characters arrive on the s_ channel, one ASCII code per request in
// s_tdata, with s_tlast high on the final (check) character of a string.
// Body characters produce nothing; each final character produces one request
// on the m_ channel whose m_tdata bit 0 is 1 for a valid ISBN-10.
// Path: a final character is first registered in the input stage, and its verdict is
// then registered in the result register that drives m_tvalid.
// Throughput: one character per cycle while no final character waits on a held verdict;
// the running count, weight and modulo-11 sum update combinationally into the state register.
// Reset (arst_n low) clears the string state and empties both registers.
// Stall: while a verdict waits on m_tready low, body characters keep flowing;
// a further final character waits in the input stage and s_tready drops until
// the waiting verdict is taken. The string state clears after every final
// character.
module isbn10_dashed_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // is_final
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

	logic                    valid_s1;
	logic [7:0]              char_s1;
	logic                    last_s1;
	isbn10_pkg::isbn_state_t state_q;
	isbn10_pkg::isbn_state_t state_nxt;
	logic                    verdict;
	logic                    out_valid_q;
	logic                    out_bit_q;
	logic                    out_free;
	logic                    consume;

	assign out_free = !out_valid_q || m_tready;
	assign consume  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	isbn10_step u_step (
		.state_cur (state_q),
		.char_code (char_s1),
		.is_final  (last_s1),
		.state_nxt (state_nxt),
		.valid_res (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			out_bit_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_bit_q};

	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("final character passed a waiting verdict");

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && last_s1) |=> (state_q == '0 && out_valid_q))
		else $error("state not cleared or verdict missing after final");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.sum_mod_eleven < isbn10_pkg::MOD_ELEVEN)
		else $error("running sum out of modulo-11 range");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.digit_weight <= state_q.char_count) &&
		({1'b0, state_q.dash_count} <= state_q.char_count))
		else $error("digit or dash count exceeds character count");

endmodule

@@ dv/isbn10_checker.sv @@
// Checker for the ISBN-10 validator: predicts each string's verdict and compares.
module isbn10_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	output int         fail_count,
	output int         strings_due
);
	timeunit 1ns;
	timeprecision 1ps;

	isbn10_pkg::isbn_state_t line_state;
	logic                    verdicts_due[$];
	logic                    due_bit;
	int                      mismatches = 0;

	function automatic logic is_numeral(input logic [7:0] c);
		return (c >= isbn10_pkg::CHAR_ZERO) && (c <= isbn10_pkg::CHAR_NINE);
	endfunction

	// Body character: length, dash bookkeeping and weighted sum.
	function automatic isbn10_pkg::isbn_state_t absorb_char(
		input isbn10_pkg::isbn_state_t st,
		input logic [7:0]              c
	);
		isbn10_pkg::isbn_state_t nx;
		nx = st;
		if (c == isbn10_pkg::CHAR_DASH) begin
			if (st.char_count == 4'd0 || st.prev_was_dash)
				nx.error_seen = 1'b1;
			if (st.dash_count != isbn10_pkg::DASH_MAX)
				nx.dash_count = st.dash_count + 3'd1;
			nx.prev_was_dash = 1'b1;
		end else begin
			if (!is_numeral(c)) begin
				nx.error_seen = 1'b1;
			end else begin
				if (st.digit_weight != isbn10_pkg::LEN_MAX)
					nx.digit_weight = st.digit_weight + 4'd1;
				nx.sum_mod_eleven = 4'((int'(st.sum_mod_eleven) +
					int'(c - isbn10_pkg::CHAR_ZERO) * int'(nx.digit_weight)) %
					int'(isbn10_pkg::MOD_ELEVEN));
			end
			nx.prev_was_dash = 1'b0;
		end
		if (st.char_count != isbn10_pkg::LEN_MAX)
			nx.char_count = st.char_count + 4'd1;
		return nx;
	endfunction

	// Check character: length and dash rules, then the checksum.
	function automatic logic closing_verdict(
		input isbn10_pkg::isbn_state_t st,
		input logic [7:0]              c
	);
		int   total;
		int   check_val;
		logic ok;
		total = (st.char_count == isbn10_pkg::LEN_MAX) ? int'(isbn10_pkg::LEN_MAX) :
			int'(st.char_count) + 1;
		ok = !st.error_seen;
		if (total == int'(isbn10_pkg::LEN_PLAIN)) begin
			if (st.dash_count != 3'd0)
				ok = 1'b0;
		end else if (total == int'(isbn10_pkg::LEN_DASHED)) begin
			if (st.dash_count != isbn10_pkg::DASHES_NEEDED)
				ok = 1'b0;
		end else begin
			ok = 1'b0;
		end
		check_val = 0;
		if (c == isbn10_pkg::CHAR_UPPER_X || c == isbn10_pkg::CHAR_LOWER_X) begin
			check_val = int'(isbn10_pkg::CHECK_TEN);
		end else if (is_numeral(c)) begin
			check_val = int'(c - isbn10_pkg::CHAR_ZERO);
		end else begin
			ok = 1'b0;
		end
		if (int'(st.sum_mod_eleven) != check_val)
			ok = 1'b0;
		return ok;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_state = '0;
			verdicts_due.delete();
			strings_due <= 0;
			fail_count  <= mismatches;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch($sformatf("verdict request 0x%02h with no string pending",
						m_tdata));
				end else begin
					due_bit = verdicts_due.pop_front();
					if (m_tdata[0] !== due_bit)
						report_mismatch($sformatf("valid_res got %b, expected %b",
							m_tdata[0], due_bit));
					if (m_tdata[7:1] !== 7'd0)
						report_mismatch($sformatf("m_tdata padding got 0x%02h, expected zero",
							m_tdata[7:1]));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tlast) begin
					verdicts_due.push_back(closing_verdict(line_state, s_tdata));
					line_state = '0;
				end else begin
					line_state = absorb_char(line_state, s_tdata);
				end
			end
			strings_due <= verdicts_due.size();
			fail_count  <= mismatches;
		end
	end

endmodule

@@ dv/isbn10_dashed_validator_test.sv @@
// Testbench top for the ISBN-10 validator: clock, reset, character stimulus and verdict.
module isbn10_dashed_validator_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	int         fail_count;
	int         strings_due;

	int         send_idle    = 0;
	int         recv_idle    = 0;
	bit         hold_request = 1'b0;
	bit         hold_done    = 1'b0;
	int         hold_left    = 0;
	int         chars_sent   = 0;
	logic [7:0] line_q[$];

	always #5 clk = ~clk;

	isbn10_dashed_validator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	isbn10_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.strings_due (strings_due)
	);

	// Receiver; one long hold-off on request so the input side backs up.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_done) begin
			m_tready <= 1'b0;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		#5_000_000;
		$display("isbn10_dashed_validator verification failed");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic push_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_q[i])
			push_char(line_q[i], i == line_q.size() - 1);
		chars_sent += line_q.size();
	endtask

	task automatic send_text(input string txt);
		line_q.delete();
		for (int i = 0; i < txt.len(); i++)
			line_q.push_back(txt[i]);
		send_line();
	endtask

	task automatic set_phase(input int snd, input int rcv, input bit hold);
		s_tvalid <= 1'b0;
		@(posedge clk);
		send_idle    = snd;
		recv_idle    = rcv;
		hold_request = hold;
		@(negedge clk);
	endtask

	// Well-formed ISBN with random digits, plain or with three dashes.
	task automatic make_isbn();
		int         sum;
		int         d;
		logic [9:0] dash_after;
		sum = 0;
		dash_after = '0;
		line_q.delete();
		if ($urandom_range(1))
			while ($countones(dash_after) < 3)
				dash_after[$urandom_range(9, 1)] = 1'b1;
		for (int i = 1; i <= 9; i++) begin
			d = $urandom_range(9);
			line_q.push_back(isbn10_pkg::CHAR_ZERO + 8'(d));
			sum += d * i;
			if (dash_after[i])
				line_q.push_back(isbn10_pkg::CHAR_DASH);
		end
		sum = sum % 11;
		if (sum == 10)
			line_q.push_back($urandom_range(1) ? isbn10_pkg::CHAR_UPPER_X :
				isbn10_pkg::CHAR_LOWER_X);
		else
			line_q.push_back(isbn10_pkg::CHAR_ZERO + 8'(sum));
	endtask

	function automatic logic [7:0] likely_char();
		case ($urandom_range(3))
			0: return isbn10_pkg::CHAR_DASH;
			1: return $urandom_range(1) ? isbn10_pkg::CHAR_UPPER_X : isbn10_pkg::CHAR_LOWER_X;
			2: return isbn10_pkg::CHAR_ZERO + 8'($urandom_range(9));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly intact; otherwise one edit, or pure noise.
	task automatic mangle_line();
		int mode;
		int idx;
		int n;
		mode = $urandom_range(9);
		idx = $urandom_range(line_q.size() - 1);
		case (mode)
			6: line_q[idx] = $urandom_range(1) ? likely_char() : 8'($urandom_range(255));
			7: if (line_q.size() > 1) line_q.delete(idx);
			8: line_q.insert(idx, likely_char());
			9: begin
				n = $urandom_range(17, 1);
				line_q.delete();
				repeat (n) line_q.push_back(likely_char());
			end
			default: ;
		endcase
	endtask

	task automatic random_lines(input int upto);
		while (chars_sent < upto) begin
			make_isbn();
			mangle_line();
			send_line();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_phase(23, 78, 1'b0);

		send_text("0306406152");
		send_text("0-306-40615-2");
		send_text("080442957X");
		send_text("080442957x");
		send_text("0306406153");
		send_text("-0-306-406152");
		send_text("0-306-406152-");
		send_text("0--306-406152");
		send_text("03064A6152");
		send_text("030640615Z");
		send_text("0-30640615");
		send_text("0-306-4061522");
		send_text("7");
		send_text("0123456789012345678");
		line_q = '{8'h00, 8'hFF, 8'h35};
		send_line();

		set_phase(23, 78, 1'b1);
		random_lines(560);
		set_phase(78, 23, 1'b0);
		random_lines(1100);
		set_phase(0, 0, 1'b0);
		random_lines(1640);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (strings_due != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("isbn10_dashed_validator verification clean");
		else
			$display("isbn10_dashed_validator verification failed");
		$finish;
	end

endmodule
